// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define SRBF_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the usual i_clk / i_rst_n pair.
`define SRBF_ASSERT(lbl, prop, msg) `SRBF_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== hw/rtl/srbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbf_pkg
// Shared constants and types of the sample ring buffer framer.
// ----------------------------------------------------------------------------
package srbf_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int CHANNELS       = 8;
    localparam int CHAN_W         = $clog2(CHANNELS);

    localparam int APB_ADDR_W     = 3;
    localparam logic [0:0] REG_FRAME_SAMPLES = 1'b0;
    localparam logic [7:0] FS_RESET = 8'd10;

    localparam logic [7:0]  HDR_SYNC0  = 8'hA5;
    localparam logic [7:0]  HDR_SYNC1  = 8'h5A;
    localparam logic [3:0]  STATUS_TAG = 4'hC;
    localparam logic [15:0] LOST_MAX   = 16'hFFFF;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Strobes from the sequencer to the sample stores.
    typedef struct packed {
        logic wr_head;
        logic wr_chan;
        logic rd_head;
        logic rd_chan;
    } t_ring_ctl;

endpackage

// ===== hw/rtl/srbf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbf_in_if / srbf_out_if
// Valid/ready channels for sample items and framed output bytes.
// ----------------------------------------------------------------------------
interface srbf_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] timestamp;
    logic [23:0] status_word;
    logic [23:0] chan_one;
    logic [23:0] chan_two;
    logic [23:0] chan_three;
    logic [23:0] chan_four;
    logic [23:0] chan_five;
    logic [23:0] chan_six;
    logic [23:0] chan_seven;
    logic [23:0] chan_eight;

    modport source (
        output valid, opcode, timestamp, status_word, chan_one, chan_two, chan_three,
               chan_four, chan_five, chan_six, chan_seven, chan_eight,
        input  ready
    );
    modport sink (
        input  valid, opcode, timestamp, status_word, chan_one, chan_two, chan_three,
               chan_four, chan_five, chan_six, chan_seven, chan_eight,
        output ready
    );
endinterface

interface srbf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic        run_end;
    logic [15:0] overflow_count;

    modport source (
        output valid, data_byte, frame_end, run_end, overflow_count,
        input  ready
    );
    modport sink (
        input  valid, data_byte, frame_end, run_end, overflow_count,
        output ready
    );
endinterface

// ===== hw/rtl/srbf_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbf_ring
// Sample stores: time stamp, status and channel memories, registered reads.
// ----------------------------------------------------------------------------
module srbf_ring #(
    parameter  int RING_DEPTH = srbf_pkg::RING_DEPTH_DEF,
    localparam int PW         = $clog2(RING_DEPTH)
) (
    input  logic                     i_clk,
    input  srbf_pkg::t_ring_ctl      i_ctl,
    input  logic [PW-1:0]            i_wr_slot,
    input  logic [srbf_pkg::CHAN_W-1:0] i_wr_chan,
    input  logic [31:0]              i_stamp,
    input  logic [23:0]              i_status,
    input  logic [23:0]              i_chan_word,
    input  logic [PW-1:0]            i_rd_slot,
    input  logic [srbf_pkg::CHAN_W-1:0] i_rd_chan,
    output logic [31:0]              o_stamp_q,
    output logic [23:0]              o_status_q,
    output logic [23:0]              o_chan_q
);

    logic [31:0] r_stamp_mem  [RING_DEPTH];
    logic [23:0] r_status_mem [RING_DEPTH];
    logic [23:0] r_chan_mem   [RING_DEPTH * srbf_pkg::CHANNELS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_head) begin
            r_stamp_mem[i_wr_slot]  <= i_stamp;
            r_status_mem[i_wr_slot] <= i_status;
        end
        if (i_ctl.rd_head) begin
            o_stamp_q  <= r_stamp_mem[i_rd_slot];
            o_status_q <= r_status_mem[i_rd_slot];
        end
    end

    // Channel words sit at slot * CHANNELS + channel.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_chan) begin
            r_chan_mem[{i_wr_slot, i_wr_chan}] <= i_chan_word;
        end
        if (i_ctl.rd_chan) begin
            o_chan_q <= r_chan_mem[{i_rd_slot, i_rd_chan}];
        end
    end

endmodule

// ===== hw/rtl/srbf_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbf_seq
// Sequencer: ring pointers, store writes, and the byte shifter of the framer.
// ----------------------------------------------------------------------------
module srbf_seq #(
    parameter  int RING_DEPTH = srbf_pkg::RING_DEPTH_DEF,
    localparam int PW         = $clog2(RING_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [7:0]                  i_frame_samples,
    srbf_in_if.sink                     i_sample,
    srbf_out_if.source                  o_byte,
    output srbf_pkg::t_ring_ctl         o_ring_ctl,
    output logic [PW-1:0]               o_wr_slot,
    output logic [srbf_pkg::CHAN_W-1:0] o_wr_chan,
    output logic [31:0]                 o_stamp,
    output logic [23:0]                 o_status,
    output logic [23:0]                 o_chan_word,
    output logic [PW-1:0]               o_rd_slot,
    output logic [srbf_pkg::CHAN_W-1:0] o_rd_chan,
    input  logic [31:0]                 i_stamp_q,
    input  logic [23:0]                 i_status_q,
    input  logic [23:0]                 i_chan_q
);

    localparam int CW = srbf_pkg::CHAN_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PUSH = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        PT_HDR   = 4'b0001,
        PT_STAMP = 4'b0010,
        PT_STAT  = 4'b0100,
        PT_CHAN  = 4'b1000
    } t_part;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        adv = (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Byte-reverse a 24-bit word so the shifter sends its top byte first.
    function automatic logic [31:0] rev24(input logic [23:0] w);
        rev24 = {8'h00, w[7:0], w[15:8], w[23:16]};
    endfunction

    t_state        r_state, n_state;
    t_part         r_part, n_part;
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [7:0]    r_fpos, n_fpos;
    logic [15:0]   r_lost, n_lost;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_bcnt, n_bcnt;
    logic [31:0]   r_shift, n_shift;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_data_byte, n_data_byte;
    logic          r_frame_end, n_frame_end;
    logic          r_run_end, n_run_end;
    logic [15:0]   r_ovf, n_ovf;

    logic [31:0]   r_ts;
    logic [23:0]   r_st;
    logic [23:0]   r_ch [srbf_pkg::CHANNELS];

    logic          accept;
    logic          push_ok;
    logic          slot_free;
    logic          word_done;
    logic [1:0]    last_bcnt;
    logic          last_of_frame;

    assign accept    = i_sample.valid && (r_state == ST_IDLE);
    assign push_ok   = (i_sample.opcode == srbf_pkg::OP_PUSH)
                    && (i_sample.status_word[23:20] == srbf_pkg::STATUS_TAG);
    assign slot_free = !r_out_valid || o_byte.ready;
    assign last_bcnt = (r_part == PT_STAMP) ? 2'd3 : 2'd2;
    assign word_done = (r_bcnt == last_bcnt);
    assign last_of_frame = ({1'b0, r_fpos} + 9'd1) >= {1'b0, i_frame_samples};

    assign i_sample.ready        = (r_state == ST_IDLE);
    assign o_byte.valid          = r_out_valid;
    assign o_byte.data_byte      = r_data_byte;
    assign o_byte.frame_end      = r_frame_end;
    assign o_byte.run_end        = r_run_end;
    assign o_byte.overflow_count = r_ovf;

    assign o_wr_slot   = r_wp;
    assign o_wr_chan   = r_cnt;
    assign o_stamp     = r_ts;
    assign o_status    = r_st;
    assign o_chan_word = r_ch[r_cnt];
    assign o_rd_slot   = r_rp;

    always_comb begin
        n_state     = r_state;
        n_part      = r_part;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_fpos      = r_fpos;
        n_lost      = r_lost;
        n_cnt       = r_cnt;
        n_bcnt      = r_bcnt;
        n_shift     = r_shift;
        n_out_valid = r_out_valid && !o_byte.ready;
        n_data_byte = r_data_byte;
        n_frame_end = r_frame_end;
        n_run_end   = r_run_end;
        n_ovf       = r_ovf;
        o_ring_ctl  = '0;
        o_rd_chan   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (push_ok) begin
                        n_state = ST_PUSH;
                    end else if (i_sample.opcode == srbf_pkg::OP_DRAIN && r_rp != r_wp) begin
                        o_ring_ctl.rd_head = 1'b1;
                        o_ring_ctl.rd_chan = 1'b1;
                        n_state            = ST_LOAD;
                    end
                end
            end
            ST_PUSH: begin
                o_ring_ctl.wr_head = (r_cnt == '0);
                o_ring_ctl.wr_chan = 1'b1;
                if (r_cnt == CW'(srbf_pkg::CHANNELS - 1)) begin
                    // Full ring: drop the oldest entry.
                    if (adv(r_wp) == r_rp) begin
                        n_rp = adv(r_rp);
                        if (r_lost != srbf_pkg::LOST_MAX) begin
                            n_lost = r_lost + 16'd1;
                        end
                    end
                    n_wp    = adv(r_wp);
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_LOAD: begin
                n_bcnt  = '0;
                n_state = ST_EMIT;
                if (r_fpos == 8'd0) begin
                    n_part  = PT_HDR;
                    n_shift = {8'h00, i_frame_samples, srbf_pkg::HDR_SYNC1,
                               srbf_pkg::HDR_SYNC0};
                end else begin
                    n_part  = PT_STAMP;
                    n_shift = i_stamp_q;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_data_byte = r_shift[7:0];
                    n_frame_end = 1'b0;
                    n_run_end   = 1'b0;
                    n_ovf       = r_lost;
                    if (!word_done) begin
                        n_shift = r_shift >> 8;
                        n_bcnt  = r_bcnt + 2'd1;
                    end else begin
                        n_bcnt = '0;
                        unique case (r_part)
                            PT_HDR: begin
                                n_part  = PT_STAMP;
                                n_shift = i_stamp_q;
                            end
                            PT_STAMP: begin
                                n_part  = PT_STAT;
                                n_shift = rev24(i_status_q);
                            end
                            PT_STAT: begin
                                // Fetch the next channel while this one goes out.
                                n_part             = PT_CHAN;
                                n_cnt              = '0;
                                n_shift            = rev24(i_chan_q);
                                o_ring_ctl.rd_chan = 1'b1;
                                o_rd_chan          = CW'(1);
                            end
                            PT_CHAN: begin
                                if (r_cnt == CW'(srbf_pkg::CHANNELS - 1)) begin
                                    n_run_end   = 1'b1;
                                    n_frame_end = last_of_frame;
                                    n_rp        = adv(r_rp);
                                    n_fpos      = last_of_frame ? 8'd0 : r_fpos + 8'd1;
                                    n_state     = ST_IDLE;
                                end else begin
                                    n_cnt              = r_cnt + 1'b1;
                                    n_shift            = rev24(i_chan_q);
                                    o_ring_ctl.rd_chan = 1'b1;
                                    o_rd_chan          = r_cnt + CW'(2);
                                end
                            end
                            default: begin
                                n_part = PT_HDR;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_part      <= PT_HDR;
            r_wp        <= '0;
            r_rp        <= '0;
            r_fpos      <= '0;
            r_lost      <= '0;
            r_cnt       <= '0;
            r_bcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_part      <= n_part;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_fpos      <= n_fpos;
            r_lost      <= n_lost;
            r_cnt       <= n_cnt;
            r_bcnt      <= n_bcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift     <= n_shift;
        r_data_byte <= n_data_byte;
        r_frame_end <= n_frame_end;
        r_run_end   <= n_run_end;
        r_ovf       <= n_ovf;
        if (accept) begin
            r_ts    <= i_sample.timestamp;
            r_st    <= i_sample.status_word;
            r_ch[0] <= i_sample.chan_one;
            r_ch[1] <= i_sample.chan_two;
            r_ch[2] <= i_sample.chan_three;
            r_ch[3] <= i_sample.chan_four;
            r_ch[4] <= i_sample.chan_five;
            r_ch[5] <= i_sample.chan_six;
            r_ch[6] <= i_sample.chan_seven;
            r_ch[7] <= i_sample.chan_eight;
        end
    end

endmodule

// ===== hw/rtl/sample_ring_buffer_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_ring_buffer_framer
// Ring of converter samples drained into a framed byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample takes push and drain beats. A push with status tag 0xC is stored
//   in the ring; a full ring overwrites its oldest entry and bumps the
//   saturating overflow count. Other pushes are dropped.
//   A push is accepted, then written to the stores with one write per channel word.
//   A drain on a non-empty ring sends one sample on o_byte as 31 bytes, or
//   34 with the A5 5A count header at the start of a frame. The first byte
//   follows the drain beat through the load and emit states, then one byte
//   a cycle while o_byte is not stalled.
//   i_sample is not ready while an item is in work.
//   A stalled o_byte holds its byte and halts the shifter.
//   Reset empties the ring, clears frame position and overflow count, and
//   sets frame_samples (APB register at address 0) to 10. Store contents
//   are not cleared; only written slots are ever read.
// ----------------------------------------------------------------------------
module sample_ring_buffer_framer #(
    parameter int RING_DEPTH = srbf_pkg::RING_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srbf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    srbf_in_if.sink                         i_sample,
    srbf_out_if.source                      o_byte
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = srbf_pkg::CHAN_W;

    logic [7:0]          r_frame_samples;
    logic                reg_sel;
    srbf_pkg::t_ring_ctl ring_ctl;
    logic [PW-1:0]       wr_slot;
    logic [PW-1:0]       rd_slot;
    logic [CW-1:0]       wr_chan;
    logic [CW-1:0]       rd_chan;
    logic [31:0]         stamp_w;
    logic [23:0]         status_w;
    logic [23:0]         chan_w;
    logic [31:0]         stamp_q;
    logic [23:0]         status_q;
    logic [23:0]         chan_q;

    assign reg_sel = (paddr[srbf_pkg::APB_ADDR_W-1:2] == srbf_pkg::REG_FRAME_SAMPLES);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {24'h000000, r_frame_samples} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_samples <= srbf_pkg::FS_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_frame_samples <= pwdata[7:0];
        end
    end

    srbf_seq #(
        .RING_DEPTH (RING_DEPTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_samples (r_frame_samples),
        .i_sample        (i_sample),
        .o_byte          (o_byte),
        .o_ring_ctl      (ring_ctl),
        .o_wr_slot       (wr_slot),
        .o_wr_chan       (wr_chan),
        .o_stamp         (stamp_w),
        .o_status        (status_w),
        .o_chan_word     (chan_w),
        .o_rd_slot       (rd_slot),
        .o_rd_chan       (rd_chan),
        .i_stamp_q       (stamp_q),
        .i_status_q      (status_q),
        .i_chan_q        (chan_q)
    );

    srbf_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_ctl       (ring_ctl),
        .i_wr_slot   (wr_slot),
        .i_wr_chan   (wr_chan),
        .i_stamp     (stamp_w),
        .i_status    (status_w),
        .i_chan_word (chan_w),
        .i_rd_slot   (rd_slot),
        .i_rd_chan   (rd_chan),
        .o_stamp_q   (stamp_q),
        .o_status_q  (status_q),
        .o_chan_q    (chan_q)
    );

endmodule

// ===== hw/rtl/srbf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbf_checker
// Port-level checks of the framer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_frame_end,
    input logic        i_run_end,
    input logic [15:0] i_overflow_count
);

    // A frame only closes on the last byte of a drain.
    property p_frame_end_on_run_end;
        (i_out_valid && i_frame_end) |-> i_run_end;
    endproperty

    // Mid-drain, no new sample beat is taken.
    property p_busy_mid_drain;
        (i_out_valid && !i_run_end) |-> !i_in_ready;
    endproperty

    // Lost count only grows.
    property p_overflow_monotonic;
        (i_out_valid && i_out_ready) |=>
            (!i_out_valid || (i_overflow_count >= $past(i_overflow_count)));
    endproperty

    // Hold a stalled output beat.
    property p_out_hold;
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_data_byte));
    endproperty

    `SRBF_ASSERT(a_frame_end_on_run_end, p_frame_end_on_run_end, "frame_end without run_end")
    `SRBF_ASSERT(a_busy_mid_drain, p_busy_mid_drain, "input ready during a drain")
    `SRBF_ASSERT(a_overflow_monotonic, p_overflow_monotonic, "overflow count went down")
    `SRBF_ASSERT(a_out_hold, p_out_hold, "stalled output beat changed")

endmodule

bind sample_ring_buffer_framer srbf_checker u_srbf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_sample.ready),
    .i_out_valid      (o_byte.valid),
    .i_out_ready      (o_byte.ready),
    .i_data_byte      (o_byte.data_byte),
    .i_frame_end      (o_byte.frame_end),
    .i_run_end        (o_byte.run_end),
    .i_overflow_count (o_byte.overflow_count)
);
